@@ rtl/flwl_pkg.sv @@
// ----------------------------------------------------------------------------
// flwl_pkg
// Shared types, codes and reset constants of the flash wear-level allocator.
// ----------------------------------------------------------------------------
package flwl_pkg;

  // Default geometry
  localparam int unsigned NumBlocksDef = 1024;
  localparam int unsigned CountBitsDef = 20;

  // Register reset values
  localparam logic [10:0] FreeThresholdRst = 11'd650;
  localparam logic [7:0]  PageLimitRst     = 8'd62;
  localparam logic [10:0] BlocksInUseRst   = 11'd1024;

  // Register indexes
  localparam logic [1:0] CfgFreeThreshold = 2'd0;
  localparam logic [1:0] CfgPageLimit     = 2'd1;
  localparam logic [1:0] CfgBlocksInUse   = 2'd2;

  // Opcodes
  localparam logic OpLoad  = 1'b0;
  localparam logic OpAlloc = 1'b1;

  // Saturation point of the reported counts
  localparam logic [31:0] Sat11Max = 32'd2047;

  typedef enum logic [1:0] {
    ST_LOADED  = 2'd0,
    ST_GRANTED = 2'd1,
    ST_RETIRED = 2'd2,
    ST_NO_FREE = 2'd3
  } status_e;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SCAN1 = 6'b000100,
    S_SCAN2 = 6'b001000,
    S_FIN   = 6'b010000,
    S_DONE  = 6'b100000
  } ctrl_state_e;

  typedef struct packed {
    status_e     status;
    logic [9:0]  grant_block;
    logic [7:0]  grant_page;
    logic [19:0] grant_erase_count;
    logic [10:0] reclaimed_blocks;
    logic [10:0] free_before;
  } res_t;

  function automatic logic [10:0] sat11(input logic [31:0] v);
    return (v > Sat11Max) ? Sat11Max[10:0] : v[10:0];
  endfunction

endpackage

@@ rtl/flash_wear_level_allocator.sv @@
// ----------------------------------------------------------------------------
// flash_wear_level_allocator
// Wear-leveling block allocator: loads table entries and grants pages from
// the least-worn free block, reclaiming waiting blocks when free runs low.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i/in_ready_o   opcode, entry, load fields
//   out      output     out_valid_o/out_ready_i status and grant fields
//   cfg      input      cfg_we_i (no wait)      cfg_idx_i, cfg_wdata_i
//
// An allocate makes two sequential passes over the first n entries of the
// table, n being the clamped blocks_in_use, through its single read port,
// one entry per cycle. After reset the table is cleared one entry per cycle
// with in_ready_o low. A finished result waits in the output register while
// the next item is taken; a stalled output holds the sequencer at its end.
// ----------------------------------------------------------------------------
module flash_wear_level_allocator import flwl_pkg::*; #(
  parameter int unsigned NUM_BLOCKS = NumBlocksDef,
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [9:0]  entry_index_i,
  input  logic [19:0] load_erase_count_i,
  input  logic        load_state_i,
  input  logic [7:0]  load_page_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [9:0]  grant_block_o,
  output logic [7:0]  grant_page_o,
  output logic [19:0] grant_erase_count_o,
  output logic [10:0] reclaimed_blocks_o,
  output logic [10:0] free_before_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [10:0] cfg_wdata_i
);

  localparam int unsigned AW = $clog2(NUM_BLOCKS);
  localparam int unsigned EW = COUNT_BITS + 9;

  logic [10:0] free_threshold_q;
  logic [7:0]  page_limit_q;
  logic [10:0] blocks_in_use_q;

  logic          res_valid;
  res_t          res;
  logic          res_take;
  logic          out_valid_q;
  res_t          out_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_threshold_q <= FreeThresholdRst;
      page_limit_q     <= PageLimitRst;
      blocks_in_use_q  <= BlocksInUseRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgFreeThreshold: free_threshold_q <= cfg_wdata_i;
        CfgPageLimit:     page_limit_q     <= cfg_wdata_i[7:0];
        CfgBlocksInUse:   blocks_in_use_q  <= cfg_wdata_i;
        default:          ;
      endcase
    end
  end

  flwl_ctrl #(
    .NumBlocks (NUM_BLOCKS),
    .CountBits (COUNT_BITS)
  ) u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .opcode_i           (opcode_i),
    .entry_index_i      (entry_index_i),
    .load_erase_count_i (load_erase_count_i),
    .load_state_i       (load_state_i),
    .load_page_i        (load_page_i),
    .free_threshold_i   (free_threshold_q),
    .page_limit_i       (page_limit_q),
    .blocks_in_use_i    (blocks_in_use_q),
    .res_valid_o        (res_valid),
    .res_o              (res),
    .res_take_i         (res_take),
    .mem_we_o           (mem_we),
    .mem_waddr_o        (mem_waddr),
    .mem_wdata_o        (mem_wdata),
    .mem_raddr_o        (mem_raddr),
    .mem_rdata_i        (mem_rdata)
  );

  flwl_mem #(
    .Depth (NUM_BLOCKS),
    .Width (EW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Move a finished result into the output register when it is free
  assign res_take = res_valid && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = out_q.status;
  assign grant_block_o       = out_q.grant_block;
  assign grant_page_o        = out_q.grant_page;
  assign grant_erase_count_o = out_q.grant_erase_count;
  assign reclaimed_blocks_o  = out_q.reclaimed_blocks;
  assign free_before_o       = out_q.free_before;

endmodule

@@ rtl/flwl_mem.sv @@
// ----------------------------------------------------------------------------
// flwl_mem
// Block table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module flwl_mem import flwl_pkg::*; #(
  parameter int unsigned Depth = NumBlocksDef,
  parameter int unsigned Width = CountBitsDef + 9,
  localparam int unsigned AW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/flwl_ctrl.sv @@
// ----------------------------------------------------------------------------
// flwl_ctrl
// Sequencer: clears the table, applies loads, and runs the count scan, the
// reclaim/min scan and the final write-back of an allocation.
// ----------------------------------------------------------------------------
module flwl_ctrl import flwl_pkg::*; #(
  parameter int unsigned NumBlocks = NumBlocksDef,
  parameter int unsigned CountBits = CountBitsDef,
  localparam int unsigned AW = $clog2(NumBlocks),
  localparam int unsigned CW = $clog2(NumBlocks + 1),
  localparam int unsigned EW = CountBits + 9
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 opcode_i,
  input  logic [9:0]           entry_index_i,
  input  logic [19:0]          load_erase_count_i,
  input  logic                 load_state_i,
  input  logic [7:0]           load_page_i,
  input  logic [10:0]          free_threshold_i,
  input  logic [7:0]           page_limit_i,
  input  logic [10:0]          blocks_in_use_i,
  output logic                 res_valid_o,
  output res_t                 res_o,
  input  logic                 res_take_i,
  output logic                 mem_we_o,
  output logic [AW-1:0]        mem_waddr_o,
  output logic [EW-1:0]        mem_wdata_o,
  output logic [AW-1:0]        mem_raddr_o,
  input  logic [EW-1:0]        mem_rdata_i
);

  ctrl_state_e state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 pend_q, pend_d;
  logic [AW-1:0]        pend_addr_q, pend_addr_d;
  logic [CW-1:0]        free_cnt_q, free_cnt_d;
  logic [CW-1:0]        recl_cnt_q, recl_cnt_d;
  logic                 found_q, found_d;
  logic [AW-1:0]        best_idx_q, best_idx_d;
  logic [CountBits-1:0] best_cnt_q, best_cnt_d;
  logic [7:0]           best_page_q, best_page_d;
  res_t                 res_q, res_d;

  logic [CW-1:0]        n_blocks;
  logic                 issue;
  logic                 reclaim;
  logic                 e_wait;
  logic [7:0]           e_page;
  logic [CountBits-1:0] e_cnt;
  logic [CountBits-1:0] e_cnt_inc;
  logic                 take_back;
  logic                 eff_wait;
  logic [7:0]           eff_page;
  logic [CountBits-1:0] eff_cnt;

  // Clamp the number of blocks taking part
  assign n_blocks = (32'(blocks_in_use_i) > 32'(NumBlocks)) ? CW'(NumBlocks)
                                                             : CW'(blocks_in_use_i);
  assign issue    = cnt_q < n_blocks;
  assign reclaim  = 32'(free_cnt_q) < 32'(free_threshold_i);

  // Split the read entry; layout is {waiting, page, count}
  assign e_wait    = mem_rdata_i[EW-1];
  assign e_page    = mem_rdata_i[EW-2 -: 8];
  assign e_cnt     = mem_rdata_i[CountBits-1:0];
  assign e_cnt_inc = (e_cnt == '1) ? e_cnt : e_cnt + 1'b1;
  assign take_back = reclaim && e_wait;
  assign eff_wait  = e_wait && !reclaim;
  assign eff_page  = take_back ? 8'd0 : e_page;
  assign eff_cnt   = take_back ? e_cnt_inc : e_cnt;

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;
  assign mem_raddr_o = cnt_q[AW-1:0];

  // Next-state logic
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    free_cnt_d  = free_cnt_q;
    recl_cnt_d  = recl_cnt_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_cnt_d  = best_cnt_q;
    best_page_d = best_page_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = pend_addr_q;
    mem_wdata_o = '0;

    case (state_q)
      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = cnt_q[AW-1:0];
        if (cnt_q == CW'(NumBlocks - 1)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          if (opcode_i == OpLoad) begin
            if (32'(entry_index_i) < 32'(NumBlocks)) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = AW'(entry_index_i);
              mem_wdata_o = {load_state_i, load_page_i, CountBits'(load_erase_count_i)};
            end
            res_d        = '0;
            res_d.status = ST_LOADED;
            state_d      = S_DONE;
          end else begin
            cnt_d      = '0;
            pend_d     = 1'b0;
            free_cnt_d = '0;
            recl_cnt_d = '0;
            found_d    = 1'b0;
            state_d    = S_SCAN1;
          end
        end
      end

      // Count free blocks
      S_SCAN1: begin
        pend_d      = issue;
        pend_addr_d = cnt_q[AW-1:0];
        if (issue) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (pend_q && !e_wait) begin
          free_cnt_d = free_cnt_q + 1'b1;
        end
        if (!issue && !pend_q) begin
          cnt_d   = '0;
          state_d = S_SCAN2;
        end
      end

      // Reclaim waiting blocks if needed and track the least-worn free block
      S_SCAN2: begin
        pend_d      = issue;
        pend_addr_d = cnt_q[AW-1:0];
        if (issue) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (pend_q) begin
          if (take_back) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = pend_addr_q;
            mem_wdata_o = {1'b0, 8'd0, e_cnt_inc};
            recl_cnt_d  = recl_cnt_q + 1'b1;
          end
          if (!eff_wait && (!found_q || eff_cnt < best_cnt_q)) begin
            found_d     = 1'b1;
            best_idx_d  = pend_addr_q;
            best_cnt_d  = eff_cnt;
            best_page_d = eff_page;
          end
        end
        if (!issue && !pend_q) begin
          state_d = S_FIN;
        end
      end

      // Grant or retire the chosen block, or report no free block, and build the result
      S_FIN: begin
        res_d                  = '0;
        res_d.reclaimed_blocks = sat11(32'(recl_cnt_q));
        res_d.free_before      = sat11(32'(free_cnt_q));
        if (!found_q) begin
          res_d.status = ST_NO_FREE;
        end else begin
          res_d.grant_block       = 10'(best_idx_q);
          res_d.grant_page        = best_page_q;
          res_d.grant_erase_count = 20'(best_cnt_q);
          mem_we_o                = 1'b1;
          mem_waddr_o             = best_idx_q;
          if (best_page_q < page_limit_i) begin
            mem_wdata_o  = {1'b0, best_page_q + 8'd1, best_cnt_q};
            res_d.status = ST_GRANTED;
          end else begin
            mem_wdata_o  = {1'b1, best_page_q, best_cnt_q};
            res_d.status = ST_RETIRED;
          end
        end
        state_d = S_DONE;
      end

      // Hold the result until the output register takes it
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      found_q <= found_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
    free_cnt_q  <= free_cnt_d;
    recl_cnt_q  <= recl_cnt_d;
    best_idx_q  <= best_idx_d;
    best_cnt_q  <= best_cnt_d;
    best_page_q <= best_page_d;
    res_q       <= res_d;
  end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the flash wear-level allocator. A shadow copy of
// the block table predicts every status and grant. Directed items cover the
// extreme fields, tie breaking, reclaim with saturating erase counts,
// retirement and the no-free case. Random phases follow under changing
// register settings, with random gaps and stalls on both channels and two
// long output hold-offs.
// ----------------------------------------------------------------------------
module tb;
  import flwl_pkg::*;

  localparam logic [19:0] WearMax    = '1;
  localparam int          StallLimit = 10000;
  localparam int          DrainCycles = 2 * NumBlocksDef + 10;

  // Shadow of the block table and the grants it still owes
  class wear_table_check;
    logic [19:0] wear [NumBlocksDef];
    bit          waiting [NumBlocksDef];
    logic [7:0]  page [NumBlocksDef];
    logic [10:0] thr;
    logic [7:0]  lim;
    logic [10:0] blocks;
    res_t        grants_due[$];
    int          mismatches;

    function new();
      foreach (wear[i]) begin
        wear[i]    = '0;
        waiting[i] = 1'b0;
        page[i]    = '0;
      end
      thr        = FreeThresholdRst;
      lim        = PageLimitRst;
      blocks     = BlocksInUseRst;
      mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [10:0] val);
      case (idx)
        CfgFreeThreshold: thr = val;
        CfgPageLimit:     lim = val[7:0];
        CfgBlocksInUse:   blocks = val;
        default: ;
      endcase
    endfunction

    // Apply one accepted item to the shadow table and queue its result
    function void note_item(logic op, logic [9:0] idx, logic [19:0] cnt, logic st,
                            logic [7:0] pg);
      res_t r;
      int   n;
      int   i;
      int   free_cnt;
      int   reclaimed;
      int   best;
      bit   found;
      r         = '0;
      free_cnt  = 0;
      reclaimed = 0;
      best      = 0;
      found     = 1'b0;
      if (op == OpLoad) begin
        wear[idx]    = cnt;
        waiting[idx] = st;
        page[idx]    = pg;
        r.status     = ST_LOADED;
        grants_due.push_back(r);
        return;
      end
      n = (blocks > NumBlocksDef) ? NumBlocksDef : int'(blocks);
      for (i = 0; i < n; i++) begin
        if (!waiting[i]) free_cnt++;
      end
      // Reclaim every waiting block when free runs low
      if (free_cnt < thr) begin
        for (i = 0; i < n; i++) begin
          if (waiting[i]) begin
            waiting[i] = 1'b0;
            page[i]    = '0;
            if (wear[i] != WearMax) wear[i]++;
            reclaimed++;
          end
        end
      end
      // Pick the least worn free block, lowest index on a tie
      for (i = 0; i < n; i++) begin
        if (!waiting[i] && (!found || wear[i] < wear[best])) begin
          best  = i;
          found = 1'b1;
        end
      end
      r.reclaimed_blocks = (reclaimed > 2047) ? 11'd2047 : 11'(reclaimed);
      r.free_before      = (free_cnt > 2047) ? 11'd2047 : 11'(free_cnt);
      if (!found) begin
        r.status = ST_NO_FREE;
      end else begin
        r.grant_block       = 10'(best);
        r.grant_page        = page[best];
        r.grant_erase_count = wear[best];
        if (page[best] < lim) begin
          page[best]++;
          r.status = ST_GRANTED;
        end else begin
          waiting[best] = 1'b1;
          r.status      = ST_RETIRED;
        end
      end
      grants_due.push_back(r);
    endfunction

    function void cmp_field(string name, logic [19:0] exp_v, logic [19:0] got_v);
      if (got_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
        mismatches++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (grants_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d", $time,
                 got.status);
        mismatches++;
        return;
      end
      want = grants_due.pop_front();
      cmp_field("status", 20'(want.status), 20'(got.status));
      cmp_field("grant_block", 20'(want.grant_block), 20'(got.grant_block));
      cmp_field("grant_page", 20'(want.grant_page), 20'(got.grant_page));
      cmp_field("grant_erase_count", want.grant_erase_count, got.grant_erase_count);
      cmp_field("reclaimed_blocks", 20'(want.reclaimed_blocks),
                20'(got.reclaimed_blocks));
      cmp_field("free_before", 20'(want.free_before), 20'(got.free_before));
    endfunction

    function int pending();
      return grants_due.size();
    endfunction
  endclass

  logic        clk_i              = 1'b0;
  logic        rst_ni             = 1'b0;
  logic        in_valid_i         = 1'b0;
  logic        in_ready_o;
  logic        opcode_i           = OpLoad;
  logic [9:0]  entry_index_i      = '0;
  logic [19:0] load_erase_count_i = '0;
  logic        load_state_i       = 1'b0;
  logic [7:0]  load_page_i        = '0;
  logic        out_valid_o;
  logic        out_ready_i        = 1'b0;
  logic [1:0]  status_o;
  logic [9:0]  grant_block_o;
  logic [7:0]  grant_page_o;
  logic [19:0] grant_erase_count_o;
  logic [10:0] reclaimed_blocks_o;
  logic [10:0] free_before_o;
  logic        cfg_we_i           = 1'b0;
  logic [1:0]  cfg_idx_i          = '0;
  logic [10:0] cfg_wdata_i        = '0;

  wear_table_check table_chk = new();
  bit              quiet     = 1'b0;
  int              idle_cycles = 0;

  flash_wear_level_allocator dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .opcode_i,
    .entry_index_i,
    .load_erase_count_i,
    .load_state_i,
    .load_page_i,
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .grant_block_o,
    .grant_page_o,
    .grant_erase_count_o,
    .reclaimed_blocks_o,
    .free_before_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i
  );

  always #4 clk_i = ~clk_i;

  // Abort when no transfer happens for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("flash_wear_level_allocator test failed");
      $finish;
    end
  end

  // Offer one item after a random gap and hold it until the transfer
  task automatic offer_item(input logic op, input logic [9:0] idx, input logic [19:0] cnt,
                            input logic st, input logic [7:0] pg);
    int gap;
    gap = quiet ? 0 : $urandom_range(7, 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    opcode_i           <= op;
    entry_index_i      <= idx;
    load_erase_count_i <= cnt;
    load_state_i       <= st;
    load_page_i        <= pg;
    do @(posedge clk_i); while (!in_ready_o);
    table_chk.note_item(op, idx, cnt, st, pg);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    table_chk.write_reg(idx, val);
  endtask

  task automatic apply_setting(input logic [10:0] thr, input logic [7:0] lim,
                               input logic [10:0] blocks);
    write_reg(CfgFreeThreshold, thr);
    write_reg(CfgPageLimit, {3'b000, lim});
    write_reg(CfgBlocksInUse, blocks);
    cfg_we_i <= 1'b0;
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic finish_phase();
    in_valid_i <= 1'b0;
    while (table_chk.pending() != 0) @(posedge clk_i);
  endtask

  // Mostly allocations; loads mostly land inside the active table
  task automatic random_item(input int n, input int lim);
    int          r;
    logic [9:0]  idx;
    logic [19:0] cnt;
    logic        st;
    logic [7:0]  pg;
    r   = $urandom_range(99, 0);
    idx = 10'($urandom_range(1023, 0));
    cnt = 20'($urandom);
    st  = 1'($urandom_range(1, 0));
    pg  = 8'($urandom_range(255, 0));
    if (r < 65) begin
      offer_item(OpAlloc, idx, cnt, st, pg);
    end else begin
      if (r < 90 && n > 0) idx = 10'($urandom_range(n - 1, 0));
      case ($urandom_range(3, 0))
        0:       cnt = 20'($urandom_range(7, 0));
        1:       cnt = WearMax - 20'($urandom_range(1, 0));
        2:       cnt = 20'($urandom);
        default: cnt = 20'($urandom_range(31, 0));
      endcase
      if ($urandom_range(3, 0) != 0) pg = 8'($urandom_range(lim + 1, 0));
      offer_item(OpLoad, idx, cnt, st, pg);
    end
  endtask

  task automatic random_phase(input int items);
    int blocks;
    int thr;
    int lim;
    blocks = ($urandom_range(4, 0) == 0) ? 1 : $urandom_range(12, 1);
    case ($urandom_range(3, 0))
      0:       thr = 0;
      1:       thr = 1024;
      default: thr = $urandom_range(blocks + 1, 0);
    endcase
    case ($urandom_range(4, 0))
      0:       lim = 0;
      1:       lim = 255;
      default: lim = $urandom_range(5, 1);
    endcase
    apply_setting(11'(thr), 8'(lim), 11'(blocks));
    repeat (items) random_item(blocks, lim);
    finish_phase();
  endtask

  // Result sink: random stalls plus two long hold-offs
  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    forever begin
      if (taken == 60 || taken == 180) begin
        stall = 300;
      end else begin
        stall = quiet ? 0 : $urandom_range(7, 0);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      table_chk.check_result(res_t'{status_e'(status_o), grant_block_o, grant_page_o,
                                    grant_erase_count_o, reclaimed_blocks_o,
                                    free_before_o});
      taken++;
    end
  end

  initial begin : stimulus
    int p;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Hold off until the table clear after reset is done
    do @(posedge clk_i); while (!in_ready_o);

    // Full table under reset settings, all-ones payload on an allocate
    offer_item(OpAlloc, 10'h3FF, WearMax, 1'b1, 8'hFF);
    finish_phase();

    // Small table: extremes, tie on counts, reclaim with saturation, retire
    apply_setting(11'd4, 8'd3, 11'd8);
    offer_item(OpLoad, 10'd0, WearMax, 1'b1, 8'hFF);
    offer_item(OpLoad, 10'd1023, 20'd0, 1'b0, 8'hFF);
    offer_item(OpLoad, 10'd1, 20'd3, 1'b0, 8'd2);
    offer_item(OpLoad, 10'd2, 20'd3, 1'b0, 8'd0);
    for (p = 3; p < 8; p++) offer_item(OpLoad, 10'(p), 20'd1, 1'b1, 8'd7);
    repeat (5) offer_item(OpAlloc, 10'd0, 20'd0, 1'b0, 8'd0);
    finish_phase();

    // Zero page limit and no reclaim: retire until nothing is free
    apply_setting(11'd0, 8'd0, 11'd2);
    repeat (3) offer_item(OpAlloc, 10'd0, 20'd0, 1'b0, 8'd0);
    finish_phase();

    // Empty table
    apply_setting(11'd1024, 8'd62, 11'd0);
    offer_item(OpAlloc, 10'd0, 20'd0, 1'b0, 8'd0);
    finish_phase();

    // Oversized table clamps to the full size
    apply_setting(11'd1024, 8'd255, 11'd2047);
    offer_item(OpAlloc, 10'd0, 20'd0, 1'b0, 8'd0);
    finish_phase();

    for (p = 0; p < 10; p++) begin
      quiet = (p % 3 == 1);
      random_phase(26);
    end
    quiet = 1'b0;

    // Let any stray result show up before the verdict
    repeat (DrainCycles) @(posedge clk_i);
    if (table_chk.mismatches == 0 && table_chk.pending() == 0) begin
      $display("flash_wear_level_allocator test passed");
    end else begin
      $display("flash_wear_level_allocator test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/flwl_pkg.sv
rtl/flwl_mem.sv
rtl/flwl_ctrl.sv
rtl/flash_wear_level_allocator.sv
tb/tb.sv
